// ===== hw/rtl/irqsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irqsa_pkg;

	localparam int TABLE_DEPTH   = 128;
	localparam int SLOT_IDX_W    = 7;
	localparam int SRC_W         = 9;
	localparam int SRC_GROUP_LSB = 5;

	// slot window for a source group: GROUP_BASE + group*GROUP_STRIDE, GROUP_SPAN+1 wide
	localparam int FREE_SLOTS    = 32;
	localparam int GROUP_BASE    = 32;
	localparam int GROUP_STRIDE  = 6;
	localparam int GROUP_SPAN    = 5;

	localparam logic [SRC_W-1:0] SEL_RESET = 9'h1FF;

	localparam logic [1:0] OP_AUTO     = 2'd0;
	localparam logic [1:0] OP_REGISTER = 2'd1;
	localparam logic [1:0] OP_RESIGN   = 2'd2;
	localparam logic [1:0] OP_QUERY    = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NULL   = 3'd1;
	localparam logic [2:0] ST_NOFREE = 3'd2;
	localparam logic [2:0] ST_RANGE  = 3'd3;
	localparam logic [2:0] ST_SOURCE = 3'd4;
	localparam logic [2:0] ST_SELECT = 3'd5;
	localparam logic [2:0] ST_TAKEN  = 3'd6;

	typedef struct packed {
		logic [2:0]            status;
		logic [SLOT_IDX_W-1:0] slot;
		logic                  sel_was_rst;
		logic                  slot_was_free;
	} res_t;

	// table update produced by one operation
	typedef struct packed {
		logic                  used_we;
		logic                  used_d;
		logic                  sel_we;
		logic                  sel_rst_d;
		logic [SLOT_IDX_W-1:0] slot;
	} upd_t;

	function automatic logic slot_fits(input logic [7:0] slot, input logic [3:0] grp);
		logic [7:0] base;
		base = 8'(grp) * 8'(GROUP_STRIDE) + 8'(GROUP_BASE);
		return (slot < 8'(FREE_SLOTS)) || ((slot >= base) && (slot <= base + 8'(GROUP_SPAN)));
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/irqsa_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irqsa_search #(
	parameter int SLOT_COUNT = 128
) (
	input  wire logic [SLOT_COUNT-1:0]          used,
	input  wire logic [3:0]                     grp,
	input  wire logic                           any,
	output logic                                found,
	output logic [irqsa_pkg::SLOT_IDX_W-1:0]    pick
);
	import irqsa_pkg::*;

	// priority encoder: lowest free slot that accepts the source group (any free slot when any is set)
	always_comb begin
		found = 1'b0;
		pick  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used[i] && (any || slot_fits(8'(i), grp))) begin
				found = 1'b1;
				pick  = SLOT_IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/irqsa_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irqsa_exec #(
	parameter int SLOT_COUNT = 128
) (
	input  wire logic [1:0]            opcode,
	input  wire logic [7:0]            irq_number,
	input  wire logic [8:0]            source,
	input  wire logic                  any_source,
	input  wire logic [31:0]           handler_address,
	input  wire logic [SLOT_COUNT-1:0] used,
	input  wire logic [SLOT_COUNT-1:0] sel_rst,
	output irqsa_pkg::res_t            res,
	output irqsa_pkg::upd_t            upd
);
	import irqsa_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam logic [8:0] SLOT_LIM = 9'(SLOT_COUNT);

	logic                  found;
	logic [SLOT_IDX_W-1:0] pick;
	logic [SLOT_IDX_W-1:0] tslot;
	logic [SLOT_W-1:0]     tidx;
	logic [3:0]            grp;
	logic                  in_range;
	logic                  tslot_ok;
	logic                  t_used;
	logic                  t_sel_rst;
	logic                  null_hdl;
	logic                  src_is_rst;
	logic                  fits;

	assign grp        = source[SRC_W-1:SRC_GROUP_LSB];
	assign in_range   = {1'b0, irq_number} < SLOT_LIM;
	assign null_hdl   = handler_address == 32'd0;
	assign src_is_rst = source == SEL_RESET;

	irqsa_search #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_search (
		.used  (used),
		.grp   (grp),
		.any   (any_source || (opcode == OP_QUERY)),
		.found (found),
		.pick  (pick)
	);

	assign tslot     = (opcode == OP_AUTO) ? pick : irq_number[SLOT_IDX_W-1:0];
	assign tslot_ok  = (opcode == OP_AUTO) ? found : in_range;
	assign tidx      = tslot[SLOT_W-1:0];
	assign t_used    = tslot_ok && used[tidx];
	assign t_sel_rst = tslot_ok && sel_rst[tidx];
	assign fits      = slot_fits({1'b0, tslot}, grp);

	always_comb begin
		res = '0;
		upd = '0;
		upd.slot = tslot;
		unique case (opcode)
			OP_AUTO, OP_REGISTER: begin
				if (opcode == OP_REGISTER) begin
					res.slot = tslot;
				end
				priority if (null_hdl) begin
					res.status = ST_NULL;
				end else if (!tslot_ok) begin
					res.status = (opcode == OP_AUTO) ? ST_NOFREE : ST_RANGE;
				end else begin
					res.slot = tslot;
					priority if (!fits) begin
						res.status = ST_SOURCE;
					end else if (!t_sel_rst) begin
						res.status = ST_SELECT;
					end else begin
						// select is written even when the slot turns out taken
						upd.sel_we    = 1'b1;
						upd.sel_rst_d = src_is_rst;
						if (t_used) begin
							res.status = ST_TAKEN;
						end else begin
							upd.used_we = 1'b1;
							upd.used_d  = 1'b1;
						end
					end
				end
			end
			OP_RESIGN: begin
				res.slot = tslot;
				if (!in_range) begin
					res.status = ST_RANGE;
				end else begin
					res.sel_was_rst   = t_sel_rst;
					res.slot_was_free = !t_used;
					upd.sel_we        = 1'b1;
					upd.sel_rst_d     = 1'b1;
					upd.used_we       = 1'b1;
					upd.used_d        = 1'b0;
				end
			end
			OP_QUERY: begin
				if (found) begin
					res.slot = pick;
				end else begin
					res.status = ST_NOFREE;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/irq_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake          | payload
// --------+--------------------+------------------------------------------------------
// in      | in_valid/in_ready  | opcode, irq_number, source, any_source, handler_address
// out     | out_valid/out_ready| status, assigned_slot, select_was_reset, slot_was_free
//
// One transaction per cycle sustained while out_ready holds; input register, then result register.
// The input register feeds the lowest-free-slot encoder and checks; the result register
// and slot table update on the same edge, so the next transaction sees the new table.
// Reset marks every slot free with its source select at the reset value; no clearing pass.
// A stalled result holds the input register, and in_ready drops until out_ready returns.

module irq_slot_allocator_unit #(
	parameter int SLOT_COUNT = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  irq_number,
	input  wire logic [8:0]  source,
	input  wire logic        any_source,
	input  wire logic [31:0] handler_address,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [6:0]       assigned_slot,
	output logic             select_was_reset,
	output logic             slot_was_free
);
	import irqsa_pkg::*;

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	logic                  valid_s1;
	logic [1:0]            opcode_s1;
	logic [7:0]            irq_number_s1;
	logic [8:0]            source_s1;
	logic                  any_source_s1;
	logic [31:0]           handler_s1;

	logic [SLOT_COUNT-1:0] used_q;
	logic [SLOT_COUNT-1:0] sel_rst_q;

	logic                  out_valid_q;
	res_t                  res_q;

	res_t                  res;
	upd_t                  upd;
	logic                  out_free;
	logic                  advance;
	logic [SLOT_W-1:0]     widx;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign widx     = upd.slot[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			irq_number_s1 <= irq_number;
			source_s1     <= source;
			any_source_s1 <= any_source;
			handler_s1    <= handler_address;
		end
	end

	irqsa_exec #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_exec (
		.opcode          (opcode_s1),
		.irq_number      (irq_number_s1),
		.source          (source_s1),
		.any_source      (any_source_s1),
		.handler_address (handler_s1),
		.used            (used_q),
		.sel_rst         (sel_rst_q),
		.res             (res),
		.upd             (upd)
	);

	// only equality with the reset select is ever observed, so one flag per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			sel_rst_q <= '1;
		end else if (advance) begin
			if (upd.used_we) begin
				used_q[widx] <= upd.used_d;
			end
			if (upd.sel_we) begin
				sel_rst_q[widx] <= upd.sel_rst_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign assigned_slot    = res_q.slot;
	assign select_was_reset = res_q.sel_was_rst;
	assign slot_was_free    = res_q.slot_was_free;

	a_used_set: assert property (@(posedge clk) disable iff (!arst_n)
		advance && upd.used_we && upd.used_d |=> used_q[$past(widx)])
		else $error("slot not marked used after successful placement");

	a_warn_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (select_was_reset || slot_was_free) |-> status == ST_OK)
		else $error("resign warning raised with non-ok status");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("transaction left input register without a result");

endmodule

`default_nettype wire
